FILE: hw/rtl/rrm_pkg.sv
// ----------------------------------------------------------------------------
// Rheostat rate mapper package
// Shared types, register indexes and the constant exponent table.
// ----------------------------------------------------------------------------
`default_nettype none

package rrm_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PROD,
      ST_DIV_LD,
      ST_DIV,
      ST_SAT,
      ST_CHECK,
      ST_LOAD,
      ST_NORM,
      ST_SQ_MUL,
      ST_SQ_UPD,
      ST_POW_MUL,
      ST_POW_UPD,
      ST_EXP_MUL,
      ST_EXP_UPD,
      ST_SCALE_MUL,
      ST_SCALE,
      ST_CLAMP,
      ST_DONE
   } state_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_SERIES_OHMS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_OHMS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANGE_PCT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_EXP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOWEST_RATE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FASTEST_RATE  = 3'd5;

   // Offset of 8.0 in Q.16, removes the eight fraction bits of the resistance.
   localparam logic [22:0] LOG_OFFSET = 23'h08_0000;
   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
   // Largest integer shift of the rate curve; a larger shift gives a zero rate.
   localparam logic [10:0] MAX_SHIFT  = 11'd33;

   typedef logic [15:0][31:0] exp2_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_v;
      v     = x;
      res   = 64'd0;
      bit_v = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (v >= res + bit_v) begin
            v   = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // Entry i holds 2^(2^-(i+1)) in Q2.30, each one the root of the previous.
   function automatic exp2_tab_type build_exp2_tab();
      logic [63:0]  t;
      exp2_tab_type tab;
      t = 64'd1 << 31;
      for (int i = 0; i < 16; i++) begin
         t      = isqrt64(t << 30);
         tab[i] = t[31:0];
      end
      return tab;
   endfunction

   localparam exp2_tab_type EXP2_TAB = build_exp2_tab();

endpackage

`default_nettype wire

FILE: hw/rtl/rrm_if.sv
// ----------------------------------------------------------------------------
// Rheostat rate mapper channels
// Valid/ready channels for converter samples and for guide rate results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrm_req_if #(parameter int SAMPLE_BITS = 10) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface rrm_rsp_if ();
   logic        valid;
   logic        ready;
   logic [23:0] guide_rate;

   modport source (output valid, output guide_rate, input ready);
   modport sink   (input valid, input guide_rate, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rheostat_rate_mapper_top.sv
// Sequencing: the restoring divider (one quotient bit per cycle), two log2 passes
//   (normalize plus 16 squaring steps) and a 16-step exp2 loop share one multiplier
//   set; a full-scale sample skips the divider.
// Throughput: one request at a time; ready is high only while the sequencer is idle.
// Reset: synchronous, active high; control and configuration registers return to
//   their defaults, the stored resistance clears to zero, and no clearing pass is needed.
// ----------------------------------------------------------------------------
// Rheostat rate mapper
// Maps a divider sample to a resistance and, on a large enough change, to a
// guide rate following a power curve.
// ----------------------------------------------------------------------------
`default_nettype none

module rheostat_rate_mapper_top #(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   rrm_req_if.sink                               req_chan,
   rrm_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [rrm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rrm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Dividend width: series ohms times the sample, with eight fraction bits.
   localparam int DW = 20 + SAMPLE_BITS + 8;
   localparam int CW = $clog2(DW);
   localparam logic [SAMPLE_BITS-1:0] FULL = {SAMPLE_BITS{1'b1}};

   // Configuration registers.
   logic [19:0] series_ff;
   logic [19:0] full_ohms_ff;
   logic [6:0]  pct_ff;
   logic [15:0] exp_ff;
   logic [23:0] slow_ff;
   logic [23:0] fast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff    <= 20'd10000;
         full_ohms_ff <= 20'd10000;
         pct_ff       <= 7'd5;
         exp_ff       <= 16'd4096;
         slow_ff      <= 24'd273;
         fast_ff      <= 24'd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            rrm_pkg::CSR_SERIES_OHMS:  series_ff    <= csr_wdata[19:0];
            rrm_pkg::CSR_FULL_OHMS:    full_ohms_ff <= csr_wdata[19:0];
            rrm_pkg::CSR_CHANGE_PCT:   pct_ff       <= csr_wdata[6:0];
            rrm_pkg::CSR_CURVE_EXP:    exp_ff       <= csr_wdata[15:0];
            rrm_pkg::CSR_SLOWEST_RATE: slow_ff      <= csr_wdata;
            rrm_pkg::CSR_FASTEST_RATE: fast_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer and datapath registers.
   rrm_pkg::state_type     state_ff, state_in;
   logic [SAMPLE_BITS-1:0] s_ff, s_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [DW-1:0]          q_ff, q_in;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] dvs_ff, dvs_in;
   logic [31:0]            r_ff, r_in;
   logic [31:0]            rep_ff, rep_in;
   logic [31:0]            lg_m_ff, lg_m_in;
   logic [4:0]             lg_n_ff, lg_n_in;
   logic [15:0]            lg_frac_ff, lg_frac_in;
   logic                   lg_sel_ff, lg_sel_in;
   logic [20:0]            log_r2_ff, log_r2_in;
   logic [22:0]            l_ff, l_in;
   logic [5:0]             k_ff, k_in;
   logic [15:0]            f_ff, f_in;
   logic [30:0]            em_ff, em_in;
   logic [23:0]            rate_ff, rate_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [23:0]            rsp_rate_ff, rsp_rate_in;

   // Shared multiplier.
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;

   rrm_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rep_ff       <= 32'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rep_ff       <= rep_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      cnt_ff      <= cnt_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      r_ff        <= r_in;
      lg_m_ff     <= lg_m_in;
      lg_n_ff     <= lg_n_in;
      lg_frac_ff  <= lg_frac_in;
      lg_sel_ff   <= lg_sel_in;
      log_r2_ff   <= log_r2_in;
      l_ff        <= l_in;
      k_ff        <= k_in;
      f_ff        <= f_in;
      em_ff       <= em_in;
      rate_ff     <= rate_in;
      rsp_rate_ff <= rsp_rate_in;
   end

   // Scratch values of the combinational block.
   logic [SAMPLE_BITS:0] rem_sh;
   logic [31:0]          diff;
   logic [38:0]          diff_x100;
   logic [34:0]          thresh;
   logic [19:0]          r2;
   logic [33:0]          sq;
   logic [15:0]          frac_new;
   logic [22:0]          mag;
   logic [25:0]          pw;
   logic [10:0]          kk;
   logic [5:0]           sh;
   logic [63:0]          scaled;
   logic [23:0]          rate_lo;

   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      r_in         = r_ff;
      rep_in       = rep_ff;
      lg_m_in      = lg_m_ff;
      lg_n_in      = lg_n_ff;
      lg_frac_in   = lg_frac_ff;
      lg_sel_in    = lg_sel_ff;
      log_r2_in    = log_r2_ff;
      l_in         = l_ff;
      k_in         = k_ff;
      f_in         = f_ff;
      em_in        = em_ff;
      rate_in      = rate_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_rate_in  = rsp_rate_ff;
      mul_a        = 32'd0;
      mul_b        = 32'd0;

      rem_sh    = {rem_ff, q_ff[DW-1]};
      diff      = (r_ff >= rep_ff) ? (r_ff - rep_ff) : (rep_ff - r_ff);
      diff_x100 = {1'b0, diff, 6'd0} + {2'b0, diff, 5'd0} + {5'b0, diff, 2'd0};
      thresh    = {27'(full_ohms_ff) * 27'(pct_ff), 8'd0};
      r2        = (full_ohms_ff == 20'd0) ? 20'd1 : full_ohms_ff;
      sq        = mul_p[63:30];
      frac_new  = {lg_frac_ff[14:0], sq[31]};
      mag       = l_ff[22] ? (~l_ff + 23'd1) : l_ff;
      pw        = mul_p[37:12];
      kk        = 11'({1'b0, pw} + 27'd65535 >> 16);
      sh        = 6'd30 + k_ff;
      scaled    = mul_p >> sh;
      rate_lo   = (rate_ff < slow_ff) ? slow_ff : rate_ff;

      unique case (state_ff)
         rrm_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               s_in     = req_chan.adc_sample;
               state_in = rrm_pkg::ST_PROD;
            end
         end
         rrm_pkg::ST_PROD: begin
            mul_a    = {12'd0, series_ff};
            mul_b    = 32'(s_ff);
            state_in = rrm_pkg::ST_DIV_LD;
         end
         rrm_pkg::ST_DIV_LD: begin
            if (s_ff == FULL) begin
               // Full-scale sample: the rheostat reads the series value.
               r_in     = {4'd0, series_ff, 8'd0};
               state_in = rrm_pkg::ST_CHECK;
            end else begin
               q_in     = {mul_p[20+SAMPLE_BITS-1:0], 8'd0};
               rem_in   = '0;
               dvs_in   = FULL - s_ff;
               cnt_in   = '0;
               state_in = rrm_pkg::ST_DIV;
            end
         end
         rrm_pkg::ST_DIV: begin
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = SAMPLE_BITS'(rem_sh - {1'b0, dvs_ff});
               q_in   = {q_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[SAMPLE_BITS-1:0];
               q_in   = {q_ff[DW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DW - 1)) begin
               state_in = rrm_pkg::ST_SAT;
            end
         end
         rrm_pkg::ST_SAT: begin
            r_in     = (|q_ff[DW-1:32]) ? 32'hFFFF_FFFF : q_ff[31:0];
            state_in = rrm_pkg::ST_CHECK;
         end
         rrm_pkg::ST_CHECK: begin
            if (diff_x100 <= {4'd0, thresh}) begin
               state_in = rrm_pkg::ST_IDLE;
            end else if (exp_ff == 16'd0) begin
               rate_in  = fast_ff;
               state_in = rrm_pkg::ST_CLAMP;
            end else if (r_ff == 32'd0) begin
               rate_in  = 24'd0;
               state_in = rrm_pkg::ST_CLAMP;
            end else begin
               lg_sel_in = 1'b0;
               state_in  = rrm_pkg::ST_LOAD;
            end
         end
         rrm_pkg::ST_LOAD: begin
            lg_m_in    = lg_sel_ff ? r_ff : {12'd0, r2};
            lg_n_in    = 5'd31;
            lg_frac_in = 16'd0;
            state_in   = rrm_pkg::ST_NORM;
         end
         rrm_pkg::ST_NORM: begin
            if (lg_m_ff[31]) begin
               lg_m_in  = {1'b0, lg_m_ff[31:1]};
               cnt_in   = '0;
               state_in = rrm_pkg::ST_SQ_MUL;
            end else begin
               lg_m_in = {lg_m_ff[30:0], 1'b0};
               lg_n_in = lg_n_ff - 5'd1;
            end
         end
         rrm_pkg::ST_SQ_MUL: begin
            mul_a    = lg_m_ff;
            mul_b    = lg_m_ff;
            state_in = rrm_pkg::ST_SQ_UPD;
         end
         rrm_pkg::ST_SQ_UPD: begin
            lg_m_in    = sq[31] ? {1'b0, sq[31:1]} : {1'b0, sq[30:0]};
            lg_frac_in = frac_new;
            cnt_in     = cnt_ff + 1'b1;
            state_in   = rrm_pkg::ST_SQ_MUL;
            if (cnt_ff[3:0] == 4'd15) begin
               if (!lg_sel_ff) begin
                  log_r2_in = {lg_n_ff, frac_new};
                  lg_sel_in = 1'b1;
                  state_in  = rrm_pkg::ST_LOAD;
               end else begin
                  l_in     = {2'b00, lg_n_ff, frac_new} - {2'b00, log_r2_ff}
                             - rrm_pkg::LOG_OFFSET;
                  state_in = rrm_pkg::ST_POW_MUL;
               end
            end
         end
         rrm_pkg::ST_POW_MUL: begin
            mul_a    = {9'd0, mag};
            mul_b    = {16'd0, exp_ff};
            state_in = rrm_pkg::ST_POW_UPD;
         end
         rrm_pkg::ST_POW_UPD: begin
            if (!l_ff[22] || pw == 26'd0) begin
               rate_in  = fast_ff;
               state_in = rrm_pkg::ST_CLAMP;
            end else if (kk > rrm_pkg::MAX_SHIFT) begin
               rate_in  = 24'd0;
               state_in = rrm_pkg::ST_CLAMP;
            end else begin
               k_in     = kk[5:0];
               f_in     = 16'(~pw[15:0] + 16'd1);
               em_in    = rrm_pkg::ONE_Q30;
               cnt_in   = '0;
               state_in = rrm_pkg::ST_EXP_MUL;
            end
         end
         rrm_pkg::ST_EXP_MUL: begin
            mul_a    = {1'b0, em_ff};
            mul_b    = rrm_pkg::EXP2_TAB[cnt_ff[3:0]];
            state_in = rrm_pkg::ST_EXP_UPD;
         end
         rrm_pkg::ST_EXP_UPD: begin
            if (f_ff[4'd15 - cnt_ff[3:0]]) begin
               em_in = mul_p[60:30];
            end
            cnt_in   = cnt_ff + 1'b1;
            state_in = (cnt_ff[3:0] == 4'd15) ? rrm_pkg::ST_SCALE_MUL
                                              : rrm_pkg::ST_EXP_MUL;
         end
         rrm_pkg::ST_SCALE_MUL: begin
            mul_a    = {8'd0, fast_ff};
            mul_b    = {1'b0, em_ff};
            state_in = rrm_pkg::ST_SCALE;
         end
         rrm_pkg::ST_SCALE: begin
            rate_in  = scaled[23:0];
            state_in = rrm_pkg::ST_CLAMP;
         end
         rrm_pkg::ST_CLAMP: begin
            // Upper limit is applied last, so it wins when the limits cross.
            rate_in  = (rate_lo > fast_ff) ? fast_ff : rate_lo;
            state_in = rrm_pkg::ST_DONE;
         end
         rrm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = rate_ff;
               rep_in       = r_ff;
               state_in     = rrm_pkg::ST_IDLE;
            end
         end
         default: state_in = rrm_pkg::ST_IDLE;
      endcase
   end

   assign req_chan.ready      = (state_ff == rrm_pkg::ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.guide_rate = rsp_rate_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rrm_mul.sv
// ----------------------------------------------------------------------------
// Rheostat rate mapper multiplier
// Shared 32 by 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module rrm_mul (
   input  wire logic        clock,
   input  wire logic [31:0] mul_a,
   input  wire logic [31:0] mul_b,
   output logic      [63:0] mul_p
);

   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_p = prod_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rrm_checker.sv
// ----------------------------------------------------------------------------
// Rheostat rate mapper checker
// Port-level properties of the mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rrm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [23:0] guide_rate
);

   // A pending result is held until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(guide_rate))
      else $error("result dropped or changed while stalled");

   // The block is busy right after it takes a request.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // No result can appear in the cycle right after a request.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result too early");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind rheostat_rate_mapper_top rrm_checker u_rrm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .guide_rate (rsp_chan.guide_rate)
);

`default_nettype wire
